/* hdl/sip_pkg.sv */
// ============================================================================
// sip_pkg
// Types, widths and arithmetic helpers for the segment intersection core.
// ============================================================================
package sip_pkg;

    localparam int COORD_W          = 32;
    localparam int DIFF_W           = COORD_W + 1;
    localparam int PROD_W           = 2 * DIFF_W;
    localparam int SIDE_W           = PROD_W + 1;
    localparam int MAG_W            = SIDE_W;
    localparam int DEN_W            = MAG_W + 1;
    localparam int REM_W            = DEN_W + 1;
    localparam int FACT_W           = 18;
    localparam int FACTOR_FRAC_BITS = 16;
    localparam int SMUL_W           = DIFF_W + FACT_W + 1;
    localparam int TRUNC_W          = SMUL_W - FACTOR_FRAC_BITS;
    localparam int SUM_W            = TRUNC_W + 2;
    localparam int NUM_COORD        = 8;
    localparam int ALPHA_W          = 17;
    localparam int GEO_STAGES       = 16;
    localparam int IN_TDATA_W       = NUM_COORD * COORD_W;
    localparam int OUT_DATA_BITS    = 2 * ALPHA_W + NUM_COORD * COORD_W;
    localparam int OUT_TDATA_W      = ((OUT_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W        = OUT_TDATA_W - OUT_DATA_BITS;
    localparam int TAG_W            = 1 + NUM_COORD * COORD_W;

    localparam logic [FACT_W-1:0] PERTURB_RESET = FACT_W'(65602);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SIDE_W-1:0]  side_t;
    typedef logic signed [SMUL_W-1:0]  smul_t;

    typedef struct packed {
        logic [NUM_COORD-1:0][COORD_W-1:0] c;
        side_t             w1;
        side_t             w2;
        side_t             v1;
        side_t             v2;
        prod_t             m0;
        prod_t             m1;
        prod_t             m2;
        prod_t             m3;
        smul_t             sx;
        smul_t             sy;
        logic              w1z;
        logic              w2z;
        logic              v1z;
        logic              v2z;
        logic              opp;
        logic              hit;
        logic [MAG_W-1:0]  np;
        logic [DEN_W-1:0]  dp;
        logic [MAG_W-1:0]  nq;
        logic [DEN_W-1:0]  dq;
    } geo_t;

    // (a - b) * (c - d), exact.
    function automatic prod_t f_mul(coord_t a, coord_t b, coord_t c, coord_t d);
        diff_t x;
        diff_t y;
        x = DIFF_W'(a) - DIFF_W'(b);
        y = DIFF_W'(c) - DIFF_W'(d);
        return x * y;
    endfunction

    function automatic side_t f_sum(prod_t a, prod_t b);
        return SIDE_W'(a) + SIDE_W'(b);
    endfunction

    // (a - b) * factor, the first half of moving a away from b.
    function automatic smul_t f_smul(coord_t a, coord_t b, logic [FACT_W-1:0] f);
        diff_t                   d;
        logic signed [FACT_W:0]  fs;
        d  = DIFF_W'(a) - DIFF_W'(b);
        fs = $signed({1'b0, f});
        return d * fs;
    endfunction

    // Truncates towards zero, adds the anchor and saturates to 32 bits.
    function automatic coord_t f_fin(smul_t prod, coord_t b);
        smul_t                    adj;
        logic signed [TRUNC_W-1:0] t;
        logic signed [SUM_W-1:0]   r;
        adj = prod[SMUL_W-1] ? prod + SMUL_W'((1 << FACTOR_FRAC_BITS) - 1) : prod;
        t   = TRUNC_W'(adj >>> FACTOR_FRAC_BITS);
        r   = SUM_W'(t) + SUM_W'(b);
        if (r[SUM_W-1:COORD_W-1] == '0 || r[SUM_W-1:COORD_W-1] == '1)
        begin
            return r[COORD_W-1:0];
        end
        return r[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    function automatic logic [MAG_W-1:0] f_mag(side_t a);
        return a[SIDE_W-1] ? MAG_W'(-a) : MAG_W'(a);
    endfunction

endpackage

/* hdl/segment_intersection_perturbed_core.sv */
// ============================================================================
// segment_intersection_perturbed_core
// Side tests, endpoint perturbation and intersection parameters for a pair
// of Q16.16 segments.
// ============================================================================
// One segment pair is taken per cycle unless the output stalls. It passes
// through sixteen geometry stages, holding the 33 by 33 bit cross product
// multipliers, the stretch multipliers, their sums and the stretch steps,
// then seventeen divider stages that each settle one quotient bit of
// both parameters. A stalled output holds the whole pipeline, so the input
// is ready whenever the final stage is empty or its transfer completes.
module segment_intersection_perturbed_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sip_pkg::FACT_W-1:0]       cfg_data,      // perturb_factor
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // p_start_x, p_start_y, p_end_x, p_end_y, q_start_x, q_start_y, q_end_x, q_end_y
    input  logic [sip_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // alpha_p, alpha_q, new_p_start_x .. new_q_end_y, zero padding
    output logic [sip_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tuser        // hit
);
    import sip_pkg::*;

    logic [FACT_W-1:0]     factor_reg;
    geo_t                  g_reg [GEO_STAGES];
    geo_t                  g_next[GEO_STAGES];
    logic [GEO_STAGES-1:0] g_valid_reg;
    logic                  en;
    logic                  div_valid;
    logic [TAG_W-1:0]      div_tag;
    logic [ALPHA_W-1:0]    alpha_p;
    logic [ALPHA_W-1:0]    alpha_q;

    assign cfg_ready = 1'b1;
    assign en        = !div_valid || m_tready;
    assign s_tready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= PERTURB_RESET;
        end
        else if (cfg_valid)
        begin
            factor_reg <= cfg_data;
        end
    end

    always_comb
    begin
        geo_t   a;
        coord_t c0, c1, c2, c3, c4, c5, c6, c7;
        for (int k = 0; k < GEO_STAGES; k++)
        begin
            if (k == 0)
            begin
                a   = '0;
                a.c = s_tdata;
            end
            else
            begin
                a = g_reg[k-1];
            end
            c0 = a.c[0];
            c1 = a.c[1];
            c2 = a.c[2];
            c3 = a.c[3];
            c4 = a.c[4];
            c5 = a.c[5];
            c6 = a.c[6];
            c7 = a.c[7];
            case (k)
                1:
                begin
                    a.m0 = f_mul(c0, c4, c5, c7);
                    a.m1 = f_mul(c1, c5, c6, c4);
                    a.m2 = f_mul(c2, c4, c5, c7);
                    a.m3 = f_mul(c3, c5, c6, c4);
                end
                2:
                begin
                    a.w1  = f_sum(a.m0, a.m1);
                    a.w2  = f_sum(a.m2, a.m3);
                    a.w1z = (a.w1 == '0);
                    a.w2z = (a.w2 == '0);
                    a.sx  = f_smul(c0, c2, factor_reg);
                    a.sy  = f_smul(c1, c3, factor_reg);
                end
                3:
                begin
                    if (a.w1z)
                    begin
                        a.c[0] = f_fin(a.sx, c2);
                        a.c[1] = f_fin(a.sy, c3);
                    end
                end
                4:
                begin
                    a.m0 = f_mul(c0, c4, c5, c7);
                    a.m1 = f_mul(c1, c5, c6, c4);
                    a.sx = f_smul(c2, c0, factor_reg);
                    a.sy = f_smul(c3, c1, factor_reg);
                end
                5:
                begin
                    if (a.w1z)
                    begin
                        a.w1 = f_sum(a.m0, a.m1);
                    end
                    if (a.w2z)
                    begin
                        a.c[2] = f_fin(a.sx, c0);
                        a.c[3] = f_fin(a.sy, c1);
                    end
                end
                6:
                begin
                    a.m2 = f_mul(c2, c4, c5, c7);
                    a.m3 = f_mul(c3, c5, c6, c4);
                end
                7:
                begin
                    if (a.w2z)
                    begin
                        a.w2 = f_sum(a.m2, a.m3);
                    end
                end
                8:
                begin
                    a.opp = (a.w1 != '0) && (a.w2 != '0)
                            && (a.w1[SIDE_W-1] != a.w2[SIDE_W-1]);
                    a.m0  = f_mul(c4, c0, c1, c3);
                    a.m1  = f_mul(c5, c1, c2, c0);
                    a.m2  = f_mul(c6, c0, c1, c3);
                    a.m3  = f_mul(c7, c1, c2, c0);
                end
                9:
                begin
                    a.v1  = f_sum(a.m0, a.m1);
                    a.v2  = f_sum(a.m2, a.m3);
                    a.v1z = (a.v1 == '0);
                    a.v2z = (a.v2 == '0);
                    a.sx  = f_smul(c4, c6, factor_reg);
                    a.sy  = f_smul(c5, c7, factor_reg);
                end
                10:
                begin
                    if (a.opp && a.v1z)
                    begin
                        a.c[4] = f_fin(a.sx, c6);
                        a.c[5] = f_fin(a.sy, c7);
                    end
                end
                11:
                begin
                    a.m0 = f_mul(c4, c0, c1, c3);
                    a.m1 = f_mul(c5, c1, c2, c0);
                    a.sx = f_smul(c6, c4, factor_reg);
                    a.sy = f_smul(c7, c5, factor_reg);
                end
                12:
                begin
                    if (a.v1z)
                    begin
                        a.v1 = f_sum(a.m0, a.m1);
                    end
                    if (a.opp && a.v2z)
                    begin
                        a.c[6] = f_fin(a.sx, c4);
                        a.c[7] = f_fin(a.sy, c5);
                    end
                end
                13:
                begin
                    a.m2 = f_mul(c6, c0, c1, c3);
                    a.m3 = f_mul(c7, c1, c2, c0);
                end
                14:
                begin
                    if (a.v2z)
                    begin
                        a.v2 = f_sum(a.m2, a.m3);
                    end
                end
                15:
                begin
                    a.hit = a.opp && ((a.v1 == '0) || (a.v2 == '0)
                            || (a.v1[SIDE_W-1] != a.v2[SIDE_W-1]));
                    if (a.hit)
                    begin
                        a.np = f_mag(a.w1);
                        a.dp = DEN_W'(f_mag(a.w1)) + DEN_W'(f_mag(a.w2));
                        a.nq = f_mag(a.v1);
                        a.dq = DEN_W'(f_mag(a.v1)) + DEN_W'(f_mag(a.v2));
                    end
                    else
                    begin
                        a.np = '0;
                        a.dp = '0;
                        a.nq = '0;
                        a.dq = '0;
                    end
                end
                default:
                begin
                    a.hit = 1'b0;
                end
            endcase
            g_next[k] = a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= '0;
        end
        else if (en)
        begin
            g_valid_reg <= {g_valid_reg[GEO_STAGES-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < GEO_STAGES; k++)
            begin
                g_reg[k] <= g_next[k];
            end
        end
    end

    sip_ratio_pipe #(
        .TAG_W (TAG_W)
    ) u_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid_reg[GEO_STAGES-1]),
        .in_tag    ({g_reg[GEO_STAGES-1].hit, g_reg[GEO_STAGES-1].c}),
        .n1        (g_reg[GEO_STAGES-1].np),
        .d1        (g_reg[GEO_STAGES-1].dp),
        .n2        (g_reg[GEO_STAGES-1].nq),
        .d2        (g_reg[GEO_STAGES-1].dq),
        .out_valid (div_valid),
        .out_tag   (div_tag),
        .q1        (alpha_p),
        .q2        (alpha_q)
    );

    assign m_tvalid = div_valid;
    assign m_tuser  = div_tag[TAG_W-1];
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, div_tag[TAG_W-2:0], alpha_q, alpha_p};

endmodule

/* hdl/sip_ratio_pipe.sv */
// ============================================================================
// sip_ratio_pipe
// Two restoring dividers side by side, one quotient bit per stage, giving
// floor(2^16 * n / d) with a tag carried alongside.
// ============================================================================
module sip_ratio_pipe #(
    parameter int TAG_W = sip_pkg::TAG_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [TAG_W-1:0]             in_tag,
    input  logic [sip_pkg::MAG_W-1:0]    n1,
    input  logic [sip_pkg::DEN_W-1:0]    d1,
    input  logic [sip_pkg::MAG_W-1:0]    n2,
    input  logic [sip_pkg::DEN_W-1:0]    d2,
    output logic                         out_valid,
    output logic [TAG_W-1:0]             out_tag,
    output logic [sip_pkg::ALPHA_W-1:0]  q1,
    output logic [sip_pkg::ALPHA_W-1:0]  q2
);
    import sip_pkg::*;

    typedef struct packed {
        logic [REM_W-1:0]   r1;
        logic [REM_W-1:0]   r2;
        logic [DEN_W-1:0]   d1;
        logic [DEN_W-1:0]   d2;
        logic [ALPHA_W-1:0] q1;
        logic [ALPHA_W-1:0] q2;
        logic [TAG_W-1:0]   tag;
    } div_t;

    div_t               st_reg [ALPHA_W];
    div_t               st_next[ALPHA_W];
    logic [ALPHA_W-1:0] valid_reg;

    always_comb
    begin
        div_t             a;
        logic [REM_W-1:0] den1;
        logic [REM_W-1:0] den2;
        for (int k = 0; k < ALPHA_W; k++)
        begin
            if (k == 0)
            begin
                a     = '0;
                a.r1  = REM_W'(n1);
                a.r2  = REM_W'(n2);
                a.d1  = d1;
                a.d2  = d2;
                a.tag = in_tag;
            end
            else
            begin
                a    = st_reg[k-1];
                a.r1 = a.r1 << 1;
                a.r2 = a.r2 << 1;
            end
            den1 = REM_W'(a.d1);
            den2 = REM_W'(a.d2);
            a.q1 = a.q1 << 1;
            a.q2 = a.q2 << 1;
            if (a.r1 >= den1)
            begin
                a.r1    = a.r1 - den1;
                a.q1[0] = 1'b1;
            end
            if (a.r2 >= den2)
            begin
                a.r2    = a.r2 - den2;
                a.q2[0] = 1'b1;
            end
            st_next[k] = a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[ALPHA_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ALPHA_W; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign out_valid = valid_reg[ALPHA_W-1];
    assign out_tag   = st_reg[ALPHA_W-1].tag;
    assign q1        = (st_reg[ALPHA_W-1].d1 == '0) ? '0 : st_reg[ALPHA_W-1].q1;
    assign q2        = (st_reg[ALPHA_W-1].d2 == '0) ? '0 : st_reg[ALPHA_W-1].q2;

endmodule

/* hdl/sip_checker.sv */
// ============================================================================
// sip_checker
// Port-level checks on the segment intersection core, bound to the top level.
// ============================================================================
module sip_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sip_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                             m_tuser
);
    import sip_pkg::*;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << 16);

    // A result without a hit carries zero parameters.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[2*ALPHA_W-1:0] == '0)
        else $error("parameters not zero on a miss");

    // Both parameters stay within the unit interval.
    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[ALPHA_W-1:0] <= ALPHA_ONE)
                  && (m_tdata[2*ALPHA_W-1:ALPHA_W] <= ALPHA_ONE))
        else $error("parameter above one");

    // A held result blocks new input transfers.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while the output is stalled");

    // A stalled result is held unchanged.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind segment_intersection_perturbed_core sip_checker u_sip_checker (.*);

/* tb/tb_segment_intersection_perturbed_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_segment_intersection_perturbed_core
// Streams segment pairs through the intersection core under several stretch
// factors, predicts every result with an exact wide-integer model and checks
// each output transfer field by field, with random stalls on both sides.
// ============================================================================
module tb_segment_intersection_perturbed_core;
    import sip_pkg::*;

    localparam int LATENCY_SLACK = 40;
    localparam int STALL_LIMIT   = 5000;

    typedef logic signed [79:0] wide_t;

    typedef struct packed {
        logic                              hit;
        logic [ALPHA_W-1:0]                ap;
        logic [ALPHA_W-1:0]                aq;
        logic [NUM_COORD-1:0][COORD_W-1:0] c;
    } seg_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [FACT_W-1:0]       cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tuser;

    logic [IN_TDATA_W-1:0]   pending_pairs[$];
    seg_result_t             expected_results[$];
    logic [FACT_W-1:0]       model_factor;
    int                      err_count;
    int                      results_seen;
    int                      hits_seen;
    int                      pairs_sent;
    int                      idle_cycles;
    bit                      in_fire;
    int                      hold_req_seq;

    segment_intersection_perturbed_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic wide_t side_test(longint px, longint py, longint ax, longint ay,
                                        longint bx, longint by);
        wide_t dx;
        wide_t dy;
        wide_t ex;
        wide_t ey;
        dx = px - ax;
        dy = py - ay;
        ex = bx - ax;
        ey = by - ay;
        return dx * (-ey) + dy * ex;
    endfunction

    function automatic longint stretch_coord(longint a, longint b, logic [FACT_W-1:0] f);
        longint prod;
        longint t;
        longint r;
        prod = (a - b) * longint'({46'd0, f});
        t = (prod >= 0) ? (prod >>> 16) : -((-prod) >>> 16);
        r = t + b;
        if (r > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
        end
        if (r < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic logic [ALPHA_W-1:0] ratio_q16(wide_t n, wide_t m);
        wide_t      an;
        wide_t      am;
        logic [99:0] den;
        an = (n < 0) ? -n : n;
        am = (m < 0) ? -m : m;
        den = 100'(an) + 100'(am);
        if (den == 0)
        begin
            return '0;
        end
        return ALPHA_W'((100'(an) << 16) / den);
    endfunction

    function automatic seg_result_t predict_intersection(logic [IN_TDATA_W-1:0] data,
                                                         logic [FACT_W-1:0] f);
        longint      c[8];
        wide_t       w1;
        wide_t       w2;
        wide_t       v1;
        wide_t       v2;
        seg_result_t r;
        for (int i = 0; i < 8; i++)
        begin
            c[i] = longint'($signed(data[i*COORD_W +: COORD_W]));
        end
        r = '0;
        w1 = side_test(c[0], c[1], c[4], c[5], c[6], c[7]);
        w2 = side_test(c[2], c[3], c[4], c[5], c[6], c[7]);
        if (w1 == 0)
        begin
            c[0] = stretch_coord(c[0], c[2], f);
            c[1] = stretch_coord(c[1], c[3], f);
            w1 = side_test(c[0], c[1], c[4], c[5], c[6], c[7]);
        end
        if (w2 == 0)
        begin
            c[2] = stretch_coord(c[2], c[0], f);
            c[3] = stretch_coord(c[3], c[1], f);
            w2 = side_test(c[2], c[3], c[4], c[5], c[6], c[7]);
        end
        if (w1 != 0 && w2 != 0 && ((w1 < 0) != (w2 < 0)))
        begin
            v1 = side_test(c[4], c[5], c[0], c[1], c[2], c[3]);
            v2 = side_test(c[6], c[7], c[0], c[1], c[2], c[3]);
            if (v1 == 0)
            begin
                c[4] = stretch_coord(c[4], c[6], f);
                c[5] = stretch_coord(c[5], c[7], f);
                v1 = side_test(c[4], c[5], c[0], c[1], c[2], c[3]);
            end
            if (v2 == 0)
            begin
                c[6] = stretch_coord(c[6], c[4], f);
                c[7] = stretch_coord(c[7], c[5], f);
                v2 = side_test(c[6], c[7], c[0], c[1], c[2], c[3]);
            end
            if (v1 == 0 || v2 == 0 || ((v1 < 0) != (v2 < 0)))
            begin
                r.hit = 1'b1;
                r.ap  = ratio_q16(w1, w2);
                r.aq  = ratio_q16(v1, v2);
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            r.c[i] = c[i][COORD_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d %s: got %h, expected %h", results_seen, what, got, want);
        err_count++;
    endtask

    // Output checking, input capture and the stall watchdog.
    always @(posedge clk)
    begin
        seg_result_t want;
        bit          moved;
        moved = 1'b0;
        in_fire = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                moved = 1'b1;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected transfer", {63'd0, m_tuser}, 64'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.hit)
                        report_mismatch("hit", 64'(m_tuser), 64'(want.hit));
                    if (m_tdata[ALPHA_W-1:0] !== want.ap)
                        report_mismatch("alpha_p", 64'(m_tdata[ALPHA_W-1:0]), 64'(want.ap));
                    if (m_tdata[2*ALPHA_W-1:ALPHA_W] !== want.aq)
                        report_mismatch("alpha_q", 64'(m_tdata[2*ALPHA_W-1:ALPHA_W]),
                                        64'(want.aq));
                    for (int i = 0; i < NUM_COORD; i++)
                    begin
                        if (m_tdata[2*ALPHA_W + i*COORD_W +: COORD_W] !== want.c[i])
                            report_mismatch($sformatf("coordinate %0d", i),
                                            64'(m_tdata[2*ALPHA_W + i*COORD_W +: COORD_W]),
                                            64'(want.c[i]));
                    end
                    if (want.hit)
                        hits_seen++;
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                moved = 1'b1;
                in_fire = 1'b1;
                expected_results = {expected_results,
                                    predict_intersection(s_tdata, model_factor)};
                pairs_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge clk)
    begin
        static int burst_left = 8;
        static int gap_left = 0;
        logic      nxt_valid;
        nxt_valid = s_tvalid;
        if (rst_n && !(s_tvalid && !in_fire))
        begin
            nxt_valid = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_pairs.size() > 0)
            begin
                s_tdata <= pending_pairs.pop_front();
                nxt_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
        end
        s_tvalid <= nxt_valid;
    end

    // Receiver: stall pattern whose density is redrawn at random, plus a long hold-off.
    always @(negedge clk)
    begin
        static int hold_left = 0;
        static int hold_seen = 0;
        static int mode_left = 0;
        static int stall_pct = 0;
        if (hold_req_seq != hold_seen)
        begin
            hold_seen = hold_req_seq;
            hold_left = 400;
        end
        if (mode_left == 0)
        begin
            mode_left = 64;
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
        end
        mode_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_pair(int px0, int py0, int px1, int py1,
                                                        int qx0, int qy0, int qx1, int qy1);
        return {qy1, qx1, qy0, qx0, py1, px1, py0, px0};
    endfunction

    task automatic add_pair(logic [IN_TDATA_W-1:0] d);
        pending_pairs = {pending_pairs, d};
    endtask

    function automatic int unit(int v);
        return v <<< 16;
    endfunction

    function automatic int grid_coord();
        int v;
        v = unit($urandom_range(0, 8) - 4);
        if ($urandom_range(0, 3) == 0)
        begin
            v = v + $urandom_range(0, 3) - 1;
        end
        return v;
    endfunction

    function automatic int edge_coord();
        int v;
        case ($urandom_range(0, 3))
            0: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: v = 32'h8000_0000 + $urandom_range(0, 3);
            2: v = $urandom_range(0, 2) - 1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_random_pair();
        logic [IN_TDATA_W-1:0] d;
        int                    k;
        k = $urandom_range(0, 9);
        for (int i = 0; i < NUM_COORD; i++)
        begin
            if (k < 6)
                d[i*COORD_W +: COORD_W] = grid_coord();
            else if (k < 8)
                d[i*COORD_W +: COORD_W] = $urandom;
            else
                d[i*COORD_W +: COORD_W] = edge_coord();
        end
        add_pair(d);
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || s_tvalid || expected_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    task automatic write_factor(logic [FACT_W-1:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        model_factor = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [FACT_W-1:0] factors[7];
        int                imax;
        int                imin;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        model_factor = PERTURB_RESET;
        err_count    = 0;
        results_seen = 0;
        hits_seen    = 0;
        pairs_sent   = 0;
        idle_cycles  = 0;
        hold_req_seq = 0;
        imax = 32'h7FFF_FFFF;
        imin = 32'h8000_0000;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pairs under the reset factor.
        add_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
        add_pair(pack_pair(imax, imax, imax, imax, imax, imax, imax, imax));
        add_pair(pack_pair(imin, imin, imin, imin, imin, imin, imin, imin));
        add_pair(pack_pair(imin, imin, imax, imax, imin, imax, imax, imin));
        add_pair(pack_pair(imax, imin, imin, imax, imin, imin, imax, imax));
        add_pair(pack_pair(0, 0, unit(2), unit(2), 0, unit(2), unit(2), 0));
        add_pair(pack_pair(unit(1), 0, unit(1), unit(3), 0, 0, unit(4), 0));
        add_pair(pack_pair(unit(1), unit(-3), unit(1), 0, 0, 0, unit(4), 0));
        add_pair(pack_pair(0, 0, unit(4), 0, unit(2), 0, unit(2), unit(3)));
        add_pair(pack_pair(0, 0, unit(4), 0, unit(2), unit(-3), unit(2), 0));
        add_pair(pack_pair(0, 0, unit(4), 0, unit(1), 0, unit(3), 0));
        add_pair(pack_pair(0, 0, unit(4), 0, 0, unit(1), unit(4), unit(1)));
        add_pair(pack_pair(0, 0, unit(2), unit(2), unit(2), unit(2), unit(4), 0));
        add_pair(pack_pair(0, 0, 1, 0, 0, 0, 0, unit(1)));
        add_pair(pack_pair(0, unit(-1), 0, 1, unit(-1), 0, unit(1), 0));
        add_pair(pack_pair(unit(-1), 0, imax, 0, imax, unit(-1), imax, unit(1)));
        add_pair(pack_pair(imin, 0, unit(1), 0, imin, unit(-1), imin, unit(1)));
        add_pair(pack_pair(0, 0, unit(1), unit(1), unit(5), 0, unit(6), 0));
        add_pair(pack_pair(0, 0, unit(4), 0, unit(4), 0, unit(4), unit(3)));
        add_pair(pack_pair(imin, imin, imax, imax, 0, 0, imax, imax));

        factors[0] = PERTURB_RESET;
        factors[1] = FACT_W'(65536);
        factors[2] = FACT_W'(131072);
        factors[3] = FACT_W'($urandom_range(65536, 131072));
        factors[4] = '0;
        factors[5] = '1;
        factors[6] = PERTURB_RESET;
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph > 0)
            begin
                write_factor(factors[ph]);
            end
            if (ph == 2)
            begin
                hold_req_seq++;
            end
            for (int n = 0; n < 100; n++)
            begin
                queue_random_pair();
            end
            wait_drained();
        end

        $display("Covered %0d segment pairs, %0d results, %0d hits, across 7 factor settings.",
                 pairs_sent, results_seen, hits_seen);
        $display("Mismatches reported: %0d", err_count);
        if (err_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
